// ===== hw/rtl/grc_pkg.sv =====
package grc_pkg;

  // Fixed point and map geometry
  localparam int FRAC      = 16;
  localparam int ONE       = 1 << FRAC;
  localparam int HALF      = 1 << (FRAC - 1);
  localparam int MAP_BITS  = 6;
  localparam int MAP_SIZE  = 1 << MAP_BITS;
  localparam int CELL_AW   = 2 * MAP_BITS;
  localparam int CELLS     = MAP_SIZE * MAP_SIZE;
  localparam int MAX_STEPS = 20;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  // Field widths
  localparam int POS_W   = 22;
  localparam int VEC_W   = 18;
  localparam int SW_W    = 13;
  localparam int STRIP_W = 12;
  localparam int ID_W    = 8;
  localparam int OPEN_W  = 17;
  localparam int DIST_W  = 24;
  localparam int CFG_W   = 22;
  localparam int CFG_AW  = 3;

  // Datapath widths
  localparam int CAM_W  = 32;
  localparam int RD_W   = 33;
  localparam int DLT_W  = 33;
  localparam int SIDE_W = 38;
  localparam int RND_W  = 24;
  localparam int NUM_W  = 26;
  localparam int DIV_NW = 40;
  localparam int DIV_DW = 32;
  localparam int MUL_W  = 34;

  localparam logic [ID_W-1:0]   DOOR_A     = 8'd98;
  localparam logic [ID_W-1:0]   DOOR_B     = 8'd99;
  localparam logic [ID_W-1:0]   OUTSIDE_ID = 8'd1;
  localparam logic [DIST_W-1:0] DIST_MAX   = '1;
  localparam logic [DIV_NW-1:0] DLT_NUM    = DIV_NW'(64'd1 << (2 * FRAC));
  localparam logic signed [RND_W-1:0] RND_ONE  = RND_W'(ONE);
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(HALF);

  typedef enum logic [CFG_AW-1:0] {
    REG_POS_X        = 3'd0,
    REG_POS_Y        = 3'd1,
    REG_DIR_X        = 3'd2,
    REG_DIR_Y        = 3'd3,
    REG_PLANE_X      = 3'd4,
    REG_PLANE_Y      = 3'd5,
    REG_SCREEN_WIDTH = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_CAST  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] plane_x;
    logic signed [VEC_W-1:0] plane_y;
    logic [SW_W-1:0]         screen_width;
  } cfg_t;

  typedef struct packed {
    logic                  action;
    logic [MAP_BITS-1:0]   cell_x;
    logic [MAP_BITS-1:0]   cell_y;
    logic [ID_W-1:0]       cell_id;
    logic [OPEN_W-1:0]     door_open;
    logic [STRIP_W-1:0]    strip;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [FRAC-1:0]   wall_x;
    logic [ID_W-1:0]   hit_id;
    logic              horizontal;
    logic              door;
    logic              door_box;
    logic [OPEN_W-1:0] texture_offset;
    logic              hit;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [CELL_AW-1:0] addr;
    logic [ID_W-1:0]    id;
    logic [OPEN_W-1:0]  open;
    logic [STRIP_W-1:0] strip;
  } cmd_t;

  // Move a cell boundary by amt towards the ray's step direction
  function automatic logic signed [RND_W-1:0] rnd_move(input logic signed [RND_W-1:0] r,
                                                       input logic neg,
                                                       input logic signed [RND_W-1:0] amt);
    return neg ? r - amt : r + amt;
  endfunction

endpackage

// ===== hw/rtl/grc_if.sv =====
interface grc_in_if;
  logic               valid;
  logic               ready;
  grc_pkg::in_item_t  data;
  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

interface grc_out_if;
  logic               valid;
  logic               ready;
  grc_pkg::out_item_t data;
  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

// ===== hw/rtl/grc_ram.sv =====
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/grc_div.sv =====
module grc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [grc_pkg::DIV_NW-1:0]  num_i,
  input  logic [grc_pkg::DIV_DW-1:0]  den_i,
  output logic                        done_o,
  output logic [grc_pkg::DIV_NW-1:0]  quo_o
);
  import grc_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW);

  logic              busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  // One quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, quo_q[DIV_NW-1]};
    diff   = trial - {1'b0, den_q};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo_d = {quo_q[DIV_NW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hw/rtl/grc_front.sv =====
module grc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  grc_in_if.snk         in_i,
  input  logic          clr_done_i,
  output logic          cmd_valid_o,
  output grc_pkg::cmd_t cmd_o,
  input  logic          cmd_ready_i
);
  import grc_pkg::*;

  localparam int QD   = 2;
  localparam int QP_W = $clog2(QD);

  cmd_t            q_mem_q [QD];
  logic [QP_W-1:0] wptr_q, rptr_q;
  logic [QP_W:0]   cnt_q;
  logic            push, pop;
  cmd_t            cmd_new;

  // Classify the incoming transaction
  always_comb begin
    cmd_new.kind  = in_i.data.action ? CMD_CAST : CMD_WRITE;
    cmd_new.addr  = {in_i.data.cell_y, in_i.data.cell_x};
    cmd_new.id    = in_i.data.cell_id;
    cmd_new.open  = in_i.data.door_open;
    cmd_new.strip = in_i.data.strip;
  end

  assign in_i.ready  = clr_done_i && (cnt_q != (QP_W+1)'(QD));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = cnt_q != '0;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[rptr_q];

  // Short queue towards the back end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (QP_W+1)'(push) - (QP_W+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wptr_q] <= cmd_new;
  end

endmodule

// ===== hw/rtl/grc_back.sv =====
module grc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  grc_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  grc_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  output logic          clr_done_o,
  grc_out_if.src        out_o
);
  import grc_pkg::*;

  typedef enum logic [19:0] {
    S_CLEAR = 20'h00001, S_IDLE  = 20'h00002, S_CAM   = 20'h00004, S_CAMW  = 20'h00008,
    S_DIRX  = 20'h00010, S_DIRY  = 20'h00020, S_DIRC  = 20'h00040, S_DLT   = 20'h00080,
    S_DLTW  = 20'h00100, S_SIDE0 = 20'h00200, S_SIDE1 = 20'h00400, S_SIDE2 = 20'h00800,
    S_ADV   = 20'h01000, S_LOOK  = 20'h02000, S_READ  = 20'h04000, S_PS    = 20'h08000,
    S_PSW   = 20'h10000, S_PMUL  = 20'h20000, S_PFRAC = 20'h40000, S_OUT   = 20'h80000
  } state_e;

  typedef enum logic [1:0] {
    PH_TEST  = 2'd0,
    PH_PASS  = 2'd1,
    PH_FINAL = 2'd2
  } phase_e;

  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  logic [CELL_AW-1:0] clr_q, clr_d;

  logic signed [CAM_W-1:0]  cam_q, cam_d;
  logic signed [RD_W-1:0]   rd_q [2], rd_d [2];
  logic [DLT_W-1:0]         dlt_q [2], dlt_d [2];
  logic [SIDE_W-1:0]        side_q [2], side_d [2];
  logic signed [RND_W-1:0]  rnd_q [2], rnd_d [2];
  logic signed [RND_W-1:0]  pr_q, pr_d;
  logic                     vert_q, vert_d, door_q, door_d, dbox_q, dbox_d, hit_q, hit_d;
  logic                     ax_q, ax_d, ta_q, ta_d, pc_q, pc_d, sdiff_q, sdiff_d;
  logic [ID_W-1:0]          id_q, id_d;
  logic [OPEN_W-1:0]        tex_q, tex_d, open_q, open_d;
  logic [STEP_W-1:0]        n_q, n_d;
  logic [DIST_W-1:0]        dist_q, dist_d;
  logic [STRIP_W-1:0]       strip_q, strip_d;
  out_item_t                res_q, res_d;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_q;

  logic                div_start, div_done;
  logic [DIV_NW-1:0]   div_num, div_q;
  logic [DIV_DW-1:0]   div_den;

  logic                       ram_we;
  logic [CELL_AW-1:0]         ram_addr;
  logic [ID_W+OPEN_W-1:0]     ram_wdata, ram_rdata;
  logic [ID_W-1:0]            ram_id;
  logic [OPEN_W-1:0]          ram_open;

  // Per-axis selections
  logic                    neg0, neg1, neg_c, neg_a, asel;
  logic [POS_W-1:0]        pos_c, pos_b;
  logic signed [RD_W-1:0]  rd_c, rd_b;
  logic [RD_W-1:0]         rdabs_c, rdabs_ax;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        numabs;
  logic [FRAC-1:0]         frac;
  logic [OPEN_W-1:0]       f0, f1;
  logic [SW_W-1:0]         width;
  logic                    front, outside;
  logic signed [RD_W-1:0]  rd_own, rd_oth;

  assign neg0   = rd_q[0][RD_W-1];
  assign neg1   = rd_q[1][RD_W-1];
  assign neg_c  = pc_q ? neg1 : neg0;
  assign neg_a  = vert_q ? neg1 : neg0;
  assign asel   = !(side_q[0] < side_q[1]);
  assign pos_c  = pc_q ? cfg_i.pos_y : cfg_i.pos_x;
  assign pos_b  = pc_q ? cfg_i.pos_x : cfg_i.pos_y;
  assign rd_c   = pc_q ? rd_q[1] : rd_q[0];
  assign rd_b   = pc_q ? rd_q[0] : rd_q[1];
  assign rd_own = ax_q ? rd_q[1] : rd_q[0];
  assign rd_oth = ax_q ? rd_q[0] : rd_q[1];
  assign rdabs_c  = rd_c[RD_W-1] ? RD_W'(-rd_c) : RD_W'(rd_c);
  assign rdabs_ax = rd_own[RD_W-1] ? RD_W'(-rd_own) : RD_W'(rd_own);
  assign num    = NUM_W'(pr_q) - NUM_W'(pos_c) + (neg_c ? NUM_W'(ONE) : NUM_W'(0));
  assign numabs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign frac   = pos_b[FRAC-1:0] + mul_q[2*FRAC-1:FRAC];
  assign f0     = neg0 ? OPEN_W'(cfg_i.pos_x[FRAC-1:0])
                       : OPEN_W'(ONE) - OPEN_W'(cfg_i.pos_x[FRAC-1:0]);
  assign f1     = neg1 ? OPEN_W'(cfg_i.pos_y[FRAC-1:0])
                       : OPEN_W'(ONE) - OPEN_W'(cfg_i.pos_y[FRAC-1:0]);
  assign width  = (cfg_i.screen_width == '0) ? SW_W'(1) : cfg_i.screen_width;
  assign front  = neg_a ? !frac[FRAC-1] : frac[FRAC-1];
  assign outside = (|rnd_q[0][RND_W-1:FRAC+MAP_BITS]) || (|rnd_q[1][RND_W-1:FRAC+MAP_BITS]);
  assign {ram_id, ram_open} = ram_rdata;

  grc_ram #(
    .WIDTH (ID_W + OPEN_W),
    .DEPTH (CELLS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  grc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  assign cmd_ready_o = state_q == S_IDLE;
  assign clr_done_o  = state_q != S_CLEAR;
  assign out_o.valid = state_q == S_OUT;
  assign out_o.data  = res_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    clr_d   = clr_q;
    cam_d   = cam_q;
    rd_d    = rd_q;
    dlt_d   = dlt_q;
    side_d  = side_q;
    rnd_d   = rnd_q;
    pr_d    = pr_q;
    vert_d  = vert_q;
    door_d  = door_q;
    dbox_d  = dbox_q;
    hit_d   = hit_q;
    ax_d    = ax_q;
    ta_d    = ta_q;
    pc_d    = pc_q;
    sdiff_d = sdiff_q;
    id_d    = id_q;
    tex_d   = tex_q;
    open_d  = open_q;
    n_d     = n_q;
    dist_d  = dist_q;
    strip_d = strip_q;
    res_d   = res_q;
    mul_a   = '0;
    mul_b   = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    ram_we    = 1'b0;
    ram_addr  = {rnd_q[1][FRAC+MAP_BITS-1:FRAC], rnd_q[0][FRAC+MAP_BITS-1:FRAC]};
    ram_wdata = {cmd_i.id, cmd_i.open};

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        ram_addr = cmd_i.addr;
        if (cmd_valid_i) begin
          if (cmd_i.kind == CMD_WRITE) begin
            ram_we = 1'b1;
          end else begin
            strip_d = cmd_i.strip;
            state_d = S_CAM;
          end
        end
      end
      // camera x = 2*strip*ONE / width - ONE
      S_CAM: begin
        div_start = 1'b1;
        div_num   = DIV_NW'({strip_q, 1'b0, {FRAC{1'b0}}});
        div_den   = DIV_DW'(width);
        state_d   = S_CAMW;
      end
      S_CAMW: begin
        if (div_done) begin
          cam_d   = CAM_W'(div_q) - CAM_W'(ONE);
          state_d = S_DIRX;
        end
      end
      // ray direction = dir + plane*cam
      S_DIRX: begin
        mul_a   = MUL_W'(cfg_i.plane_x);
        mul_b   = MUL_W'(cam_q);
        state_d = S_DIRY;
      end
      S_DIRY: begin
        rd_d[0] = RD_W'(cfg_i.dir_x) + mul_q[FRAC+RD_W-1:FRAC];
        mul_a   = MUL_W'(cfg_i.plane_y);
        mul_b   = MUL_W'(cam_q);
        state_d = S_DIRC;
      end
      S_DIRC: begin
        rd_d[1] = RD_W'(cfg_i.dir_y) + mul_q[FRAC+RD_W-1:FRAC];
        ax_d    = 1'b0;
        state_d = S_DLT;
      end
      // delta distance per axis
      S_DLT: begin
        if (rd_oth == '0) begin
          dlt_d[ax_q] = '0;
          ax_d        = 1'b1;
          if (ax_q) state_d = S_SIDE0;
        end else if (rd_own == '0) begin
          dlt_d[ax_q] = DLT_W'(ONE);
          ax_d        = 1'b1;
          if (ax_q) state_d = S_SIDE0;
        end else begin
          div_start = 1'b1;
          div_num   = DLT_NUM;
          div_den   = DIV_DW'(rdabs_ax);
          state_d   = S_DLTW;
        end
      end
      S_DLTW: begin
        if (div_done) begin
          dlt_d[ax_q] = div_q[DLT_W-1:0];
          ax_d        = 1'b1;
          state_d     = ax_q ? S_SIDE0 : S_DLT;
        end
      end
      // initial side distances and walk state
      S_SIDE0: begin
        mul_a    = MUL_W'(f0);
        mul_b    = MUL_W'(dlt_q[0]);
        rnd_d[0] = RND_W'({cfg_i.pos_x[POS_W-1:FRAC], {FRAC{1'b0}}});
        rnd_d[1] = RND_W'({cfg_i.pos_y[POS_W-1:FRAC], {FRAC{1'b0}}});
        vert_d   = 1'b0;
        door_d   = 1'b0;
        dbox_d   = 1'b0;
        hit_d    = 1'b0;
        id_d     = '0;
        tex_d    = '0;
        n_d      = '0;
        state_d  = S_SIDE1;
      end
      S_SIDE1: begin
        side_d[0] = SIDE_W'(mul_q[FRAC+DLT_W-1:FRAC]);
        mul_a     = MUL_W'(f1);
        mul_b     = MUL_W'(dlt_q[1]);
        state_d   = S_SIDE2;
      end
      S_SIDE2: begin
        side_d[1] = SIDE_W'(mul_q[FRAC+DLT_W-1:FRAC]);
        state_d   = S_ADV;
      end
      // one DDA step, or the start of the final distance once hit or after MAX_STEPS steps
      S_ADV: begin
        if (hit_q || n_q == STEP_W'(MAX_STEPS)) begin
          pc_d    = vert_q;
          pr_d    = vert_q ? rnd_q[1] : rnd_q[0];
          ph_d    = PH_FINAL;
          state_d = S_PS;
        end else begin
          side_d[asel] = side_q[asel] + SIDE_W'(dlt_q[asel]);
          rnd_d[asel]  = rnd_move(rnd_q[asel], asel ? neg1 : neg0, RND_ONE);
          vert_d       = asel;
          n_d          = n_q + 1'b1;
          state_d      = S_LOOK;
        end
      end
      S_LOOK: begin
        if (dbox_q) begin
          hit_d   = 1'b1;
          state_d = S_ADV;
        end else if (outside) begin
          id_d    = OUTSIDE_ID;
          hit_d   = 1'b1;
          state_d = S_ADV;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        id_d   = ram_id;
        open_d = ram_open;
        if (ram_id == DOOR_A || ram_id == DOOR_B) begin
          // look one step ahead to see where the ray leaves the door cell
          ta_d    = asel;
          pc_d    = asel;
          pr_d    = rnd_move(asel ? rnd_q[1] : rnd_q[0], asel ? neg1 : neg0, RND_ONE);
          ph_d    = PH_TEST;
          state_d = S_PS;
        end else begin
          if (ram_id != '0) hit_d = 1'b1;
          state_d = S_ADV;
        end
      end
      // perpendicular distance and face fraction on axis pc_q at boundary pr_q
      S_PS: begin
        if (rd_c == '0) begin
          dist_d  = DIST_MAX;
          state_d = S_PMUL;
        end else begin
          div_start = 1'b1;
          div_num   = DIV_NW'({numabs, {FRAC{1'b0}}});
          div_den   = DIV_DW'(rdabs_c);
          sdiff_d   = num[NUM_W-1] ^ rd_c[RD_W-1];
          state_d   = S_PSW;
        end
      end
      S_PSW: begin
        if (div_done) begin
          if (sdiff_q) begin
            dist_d = '0;
          end else if (|div_q[DIV_NW-1:DIST_W]) begin
            dist_d = DIST_MAX;
          end else begin
            dist_d = div_q[DIST_W-1:0];
          end
          state_d = S_PMUL;
        end
      end
      S_PMUL: begin
        mul_a   = MUL_W'(dist_q);
        mul_b   = MUL_W'(rd_b);
        state_d = S_PFRAC;
      end
      S_PFRAC: begin
        state_d = S_ADV;
        unique case (ph_q)
          PH_FINAL: begin
            res_d.distance       = dist_q;
            res_d.wall_x         = frac;
            res_d.hit_id         = id_q;
            res_d.horizontal     = !vert_q;
            res_d.door           = door_q;
            res_d.door_box       = dbox_q;
            res_d.texture_offset = tex_q;
            res_d.hit            = hit_q;
            state_d              = S_OUT;
          end
          PH_TEST: begin
            if (front || ta_q == vert_q) begin
              tex_d   = open_q;
              pc_d    = vert_q;
              pr_d    = rnd_move(vert_q ? rnd_q[1] : rnd_q[0], neg_a, RND_HALF);
              ph_d    = PH_PASS;
              state_d = S_PS;
            end else begin
              // door side: take the look-ahead step
              side_d[ta_q] = side_q[ta_q] + SIDE_W'(dlt_q[ta_q]);
              rnd_d[ta_q]  = rnd_move(rnd_q[ta_q], ta_q ? neg1 : neg0, RND_ONE);
              vert_d       = ta_q;
              dbox_d       = 1'b1;
              hit_d        = 1'b1;
            end
          end
          PH_PASS: begin
            if (({1'b0, frac} <= open_q) && (frac != '0)) begin
              if (ta_q != vert_q) dbox_d = 1'b1;
            end else begin
              rnd_d[vert_q] = rnd_move(rnd_q[vert_q], neg_a, RND_HALF);
              door_d        = 1'b1;
              hit_d         = 1'b1;
            end
          end
          default: state_d = S_ADV;
        endcase
      end
      S_OUT: begin
        if (out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ph_q    <= PH_FINAL;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ph_q    <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q   <= mul_a * mul_b;
    cam_q   <= cam_d;
    rd_q    <= rd_d;
    dlt_q   <= dlt_d;
    side_q  <= side_d;
    rnd_q   <= rnd_d;
    pr_q    <= pr_d;
    vert_q  <= vert_d;
    door_q  <= door_d;
    dbox_q  <= dbox_d;
    hit_q   <= hit_d;
    ax_q    <= ax_d;
    ta_q    <= ta_d;
    pc_q    <= pc_d;
    sdiff_q <= sdiff_d;
    id_q    <= id_d;
    tex_q   <= tex_d;
    open_q  <= open_d;
    n_q     <= n_d;
    dist_q  <= dist_d;
    strip_q <= strip_d;
    res_q   <= res_d;
  end

endmodule

// ===== hw/rtl/grid_raycast_dda_with_doors.sv =====
// Grid raycaster with sliding doors, one screen column per cast.
// in_i carries write and cast transactions; out_o returns one result
// per cast and nothing for a write. Registers (viewer position, direction,
// camera plane, screen width) must be loaded through cfg_we_i/cfg_idx_i/cfg_data_i
// only while the block is idle; the block itself does not enforce this.
// A write is stored to the map straight from the idle state. A cast's set-up and
// final distance take up to four passes through the shared serial divider, and
// each door met adds up to two further distance divisions through that same divider.
// A two-entry queue sits in front of the engine, so transactions are taken
// while a cast is in progress or a result waits on a stalled receiver; the
// result is held on out_o until it is taken.
// After reset the map is swept to empty, one cell at a time over all 4096 cells,
// during which in_i.ready stays low; configuration writes are accepted throughout.
module grid_raycast_dda_with_doors (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  grc_in_if.snk                       in_i,
  grc_out_if.src                      out_o,
  input  logic                        cfg_we_i,
  input  logic [grc_pkg::CFG_AW-1:0]  cfg_idx_i,
  input  logic [grc_pkg::CFG_W-1:0]   cfg_data_i
);
  import grc_pkg::*;

  cfg_t cfg_q;
  logic cmd_valid, cmd_ready, clr_done;
  cmd_t cmd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x        <= POS_W'(131072);
      cfg_q.pos_y        <= POS_W'(131072);
      cfg_q.dir_x        <= -VEC_W'(65536);
      cfg_q.dir_y        <= '0;
      cfg_q.plane_x      <= '0;
      cfg_q.plane_y      <= VEC_W'(43254);
      cfg_q.screen_width <= SW_W'(640);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POS_X:        cfg_q.pos_x        <= cfg_data_i[POS_W-1:0];
        REG_POS_Y:        cfg_q.pos_y        <= cfg_data_i[POS_W-1:0];
        REG_DIR_X:        cfg_q.dir_x        <= cfg_data_i[VEC_W-1:0];
        REG_DIR_Y:        cfg_q.dir_y        <= cfg_data_i[VEC_W-1:0];
        REG_PLANE_X:      cfg_q.plane_x      <= cfg_data_i[VEC_W-1:0];
        REG_PLANE_Y:      cfg_q.plane_y      <= cfg_data_i[VEC_W-1:0];
        REG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_data_i[SW_W-1:0];
        default: ;
      endcase
    end
  end

  grc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .clr_done_i  (clr_done),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  grc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .clr_done_o  (clr_done),
    .out_o       (out_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import grc_pkg::*;

  localparam longint FX_ONE  = 64'd1 << 16;
  localparam longint FX_HALF = 64'd1 << 15;
  localparam longint FX_DMAX = 64'hFFFFFF;

  // Ray walk state of the predictor
  typedef struct {
    longint      side [2];
    longint      delta [2];
    longint      rnd [2];
    longint      dir [2];
    longint      stp [2];
    bit          vert;
    bit          door;
    bit          dbox;
    bit          hit;
    int unsigned id;
    int unsigned tex;
  } ray_walk_t;

  logic clk_i;
  logic rst_ni;
  logic              cfg_we_i;
  logic [CFG_AW-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;

  grc_in_if  in_if ();
  grc_out_if out_if ();

  grid_raycast_dda_with_doors u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow map and registers
  byte unsigned map_ids [CELLS];
  int unsigned  map_opens [CELLS];
  logic [POS_W-1:0]        view_pos [2];
  logic signed [VEC_W-1:0] view_dir [2];
  logic signed [VEC_W-1:0] view_plane [2];
  logic [SW_W-1:0]         view_width;

  in_item_t  pending_items [$];
  out_item_t expected_hits [$];
  int        fail_count;
  int        tx_gap;
  int        rx_gap;
  bit        tx_hold;
  bit        no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #300000000;
    $display("[grid_raycast_dda_with_doors] ERROR");
    $finish;
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Step to the nearer boundary
  function automatic void ray_step(inout ray_walk_t r);
    int a;
    a = (r.side[0] < r.side[1]) ? 0 : 1;
    r.side[a] += r.delta[a];
    r.rnd[a]  += r.stp[a] * FX_ONE;
    r.vert    = (a == 1);
  endfunction

  function automatic longint perp_dist(ray_walk_t r);
    int     a;
    longint num;
    longint q;
    a   = r.vert ? 1 : 0;
    num = r.rnd[a] - longint'(view_pos[a]) + ((r.stp[a] < 0) ? FX_ONE : 0);
    if (r.dir[a] == 0) return FX_DMAX;
    q = (num * FX_ONE) / r.dir[a];
    if (q < 0) q = 0;
    if (q > FX_DMAX) q = FX_DMAX;
    return q;
  endfunction

  function automatic longint wall_frac(ray_walk_t r, longint hit_dist);
    int     b;
    longint w;
    b = r.vert ? 0 : 1;
    w = longint'(view_pos[b]) + ((hit_dist * r.dir[b]) >>> 16);
    return w & (FX_ONE - 1);
  endfunction

  // Recessed door face or door side
  function automatic void door_probe(inout ray_walk_t r, input int idx);
    int          a;
    ray_walk_t   t;
    ray_walk_t   u;
    longint      tw;
    longint      w2;
    longint      opening;
    bit          front;
    a       = r.vert ? 1 : 0;
    opening = map_opens[idx];
    t       = r;
    ray_step(t);
    tw    = wall_frac(t, perp_dist(t));
    front = (r.dir[a] < 0) ? (tw < FX_HALF) : (tw >= FX_HALF);
    r.tex = map_opens[idx];
    if (front || t.vert == r.vert) begin
      u = r;
      u.rnd[a] += u.stp[a] * FX_HALF;
      w2 = wall_frac(u, perp_dist(u));
      if (w2 <= opening && w2 > 0) begin
        if (r.rnd[a] == t.rnd[a]) r.dbox = 1'b1;
        return;
      end
      r.rnd[a] += r.stp[a] * FX_HALF;
      r.door = 1'b1;
    end else begin
      r = t;
      r.dbox = 1'b1;
    end
    r.hit = 1'b1;
  endfunction

  function automatic out_item_t cast_column(logic [STRIP_W-1:0] strip);
    ray_walk_t r;
    out_item_t o;
    longint    w;
    longint    cam;
    longint    d;
    longint    frac;
    longint    cx;
    longint    cy;
    longint    hit_dist;
    int        idx;
    r = '{default: 0};
    w   = (view_width == 0) ? 1 : longint'(view_width);
    cam = (2 * longint'(strip) * FX_ONE) / w - FX_ONE;
    for (int a = 0; a < 2; a++)
      r.dir[a] = longint'(view_dir[a]) + ((longint'(view_plane[a]) * cam) >>> 16);
    for (int a = 0; a < 2; a++) begin
      d    = r.dir[a];
      frac = longint'(view_pos[a]) & (FX_ONE - 1);
      if (r.dir[1-a] == 0) r.delta[a] = 0;
      else if (d == 0) r.delta[a] = FX_ONE;
      else r.delta[a] = (FX_ONE * FX_ONE) / ((d < 0) ? -d : d);
      r.rnd[a]  = longint'(view_pos[a]) - frac;
      r.stp[a]  = (d < 0) ? -1 : 1;
      r.side[a] = (((d < 0) ? frac : FX_ONE - frac) * r.delta[a]) >>> 16;
    end
    for (int n = 0; n < MAX_STEPS && !r.hit; n++) begin
      ray_step(r);
      if (r.dbox) begin
        r.hit = 1'b1;
        continue;
      end
      cx = r.rnd[0] >>> 16;
      cy = r.rnd[1] >>> 16;
      if (cx < 0 || cy < 0 || cx >= MAP_SIZE || cy >= MAP_SIZE) begin
        r.id  = OUTSIDE_ID;
        r.hit = 1'b1;
        continue;
      end
      idx  = int'(cy * MAP_SIZE + cx);
      r.id = map_ids[idx];
      if (r.id == DOOR_A || r.id == DOOR_B) door_probe(r, idx);
      else if (r.id > 0) r.hit = 1'b1;
    end
    hit_dist         = perp_dist(r);
    o.distance       = hit_dist[DIST_W-1:0];
    o.wall_x         = FRAC'(wall_frac(r, hit_dist));
    o.hit_id         = r.id[ID_W-1:0];
    o.horizontal     = !r.vert;
    o.door           = r.door;
    o.door_box       = r.dbox;
    o.texture_offset = r.tex[OPEN_W-1:0];
    o.hit            = r.hit;
    return o;
  endfunction

  function automatic void apply_item(in_item_t it);
    if (it.action == CMD_WRITE) begin
      map_ids[{it.cell_y, it.cell_x}]   = it.cell_id;
      map_opens[{it.cell_y, it.cell_x}] = it.door_open;
    end else begin
      expected_hits.push_back(cast_column(it.strip));
    end
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      tx_gap      <= 0;
    end else begin
      if (in_if.valid && in_if.ready) apply_item(in_if.data);
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap != 0) begin
          in_if.valid <= 1'b0;
          tx_gap      <= tx_gap - 1;
        end else if (pending_items.size() != 0 && !tx_hold) begin
          in_if.valid <= 1'b1;
          in_if.data  <= pending_items.pop_front();
          tx_gap      <= draw_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_gap       <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_hits.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count++;
        end else begin
          check_field("distance", expected_hits[0].distance, out_if.data.distance);
          check_field("wall_x", expected_hits[0].wall_x, out_if.data.wall_x);
          check_field("hit_id", expected_hits[0].hit_id, out_if.data.hit_id);
          check_field("horizontal", expected_hits[0].horizontal, out_if.data.horizontal);
          check_field("door", expected_hits[0].door, out_if.data.door);
          check_field("door_box", expected_hits[0].door_box, out_if.data.door_box);
          check_field("texture_offset", expected_hits[0].texture_offset,
                      out_if.data.texture_offset);
          check_field("hit", expected_hits[0].hit, out_if.data.hit);
          void'(expected_hits.pop_front());
        end
      end
      if (rx_gap != 0) begin
        out_if.ready <= 1'b0;
        rx_gap       <= rx_gap - 1;
      end else begin
        out_if.ready <= 1'b1;
        rx_gap       <= draw_gap();
      end
    end
  end

  task automatic reg_write(cfg_reg_e idx, longint value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_W-1:0];
    case (idx)
      REG_POS_X:   view_pos[0]   = value[POS_W-1:0];
      REG_POS_Y:   view_pos[1]   = value[POS_W-1:0];
      REG_DIR_X:   view_dir[0]   = value[VEC_W-1:0];
      REG_DIR_Y:   view_dir[1]   = value[VEC_W-1:0];
      REG_PLANE_X: view_plane[0] = value[VEC_W-1:0];
      REG_PLANE_Y: view_plane[1] = value[VEC_W-1:0];
      default:     view_width    = value[SW_W-1:0];
    endcase
  endtask

  task automatic load_view(longint px, longint py, longint dx, longint dy,
                           longint plx, longint ply, longint sw);
    reg_write(REG_POS_X, px);
    reg_write(REG_POS_Y, py);
    reg_write(REG_DIR_X, dx);
    reg_write(REG_DIR_Y, dy);
    reg_write(REG_PLANE_X, plx);
    reg_write(REG_PLANE_Y, ply);
    reg_write(REG_SCREEN_WIDTH, sw);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every queued transaction is taken and every result is back
  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_if.valid || expected_hits.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic void push_cell(int x, int y, int id, int opening);
    in_item_t it;
    it           = '0;
    it.action    = CMD_WRITE;
    it.cell_x    = x[MAP_BITS-1:0];
    it.cell_y    = y[MAP_BITS-1:0];
    it.cell_id   = id[ID_W-1:0];
    it.door_open = opening[OPEN_W-1:0];
    it.strip     = STRIP_W'($urandom_range(0, 4095));
    pending_items.push_back(it);
  endfunction

  function automatic void push_cast(int strip);
    in_item_t it;
    it        = '0;
    it.action = CMD_CAST;
    it.cell_x    = MAP_BITS'($urandom_range(0, 63));
    it.cell_y    = MAP_BITS'($urandom_range(0, 63));
    it.cell_id   = ID_W'($urandom_range(0, 255));
    it.door_open = OPEN_W'($urandom_range(0, 131071));
    it.strip  = strip[STRIP_W-1:0];
    pending_items.push_back(it);
  endfunction

  function automatic int rand_opening();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 65536;
    if (r == 2) return $urandom_range(65537, 131071);
    return $urandom_range(1, 65535);
  endfunction

  // Random map writes, mostly near the viewer, mixed with casts
  function automatic void fill_random(int count);
    int vx;
    int vy;
    int r;
    int id;
    vx = int'(view_pos[0] >> 16);
    vy = int'(view_pos[1] >> 16);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        r = $urandom_range(0, 9);
        if (r < 3) id = 0;
        else if (r < 5) id = DOOR_A;
        else if (r < 7) id = DOOR_B;
        else id = $urandom_range(1, 255);
        push_cell((vx + $urandom_range(0, 12) + 58) & 63,
                  (vy + $urandom_range(0, 12) + 58) & 63, id, rand_opening());
      end else if (r < 36) begin
        push_cell($urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 255), $urandom_range(0, 131071));
      end else if (r < 92) begin
        push_cast($urandom_range(0, (view_width == 0) ? 0 : int'(view_width) - 1) & 4095);
      end else begin
        push_cast($urandom_range(0, 4095));
      end
    end
  endfunction

  function automatic longint rand_vec();
    return longint'($urandom_range(0, 262143)) - 131072;
  endfunction

  initial begin
    fail_count   = 0;
    tx_hold      = 1'b0;
    no_idle      = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    for (int i = 0; i < CELLS; i++) begin
      map_ids[i]   = 0;
      map_opens[i] = 0;
    end
    view_pos[0]   = 22'd131072;
    view_pos[1]   = 22'd131072;
    view_dir[0]   = -18'sd65536;
    view_dir[1]   = 18'sd0;
    view_plane[0] = 18'sd0;
    view_plane[1] = 18'sd43254;
    view_width    = 13'd640;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: walls and doors around the viewer at the reset view
    push_cast(0);
    push_cell(0, 2, 255, 0);
    push_cell(1, 2, DOOR_A, 32768);
    push_cast(320);
    push_cell(1, 2, DOOR_B, 65536);
    push_cast(320);
    push_cell(1, 2, DOOR_A, 131071);
    push_cast(320);
    push_cell(1, 2, DOOR_B, 0);
    push_cast(320);
    push_cast(0);
    push_cast(639);
    push_cast(4095);
    push_cell(1, 1, DOOR_A, 40000);
    push_cell(1, 3, DOOR_B, 20000);
    push_cast(100);
    push_cast(540);
    push_cell(63, 63, 7, 0);
    push_cell(1, 2, 0, 0);
    push_cast(320);
    push_cell(0, 2, 0, 0);
    push_cast(320);
    drain();

    // Register extremes, then random settings
    for (int ph = 0; ph < 10; ph++) begin
      no_idle = (ph % 4 == 3);
      case (ph)
        0: load_view(131072, 131072, -65536, 0, 0, 43254, 640);
        1: load_view(4194303, 4194303, -131072, -131072, 131071, -131072, 4096);
        2: load_view(0, 0, 131071, 131071, -131072, 131071, 1);
        3: load_view(32768 + 65536 * 5, 65536 * 5, 0, 65536, 43254, 0, 0);
        4: load_view(65536 * 40 + 32768, 65536 * 40 + 32768, 0, 0, 0, 0, 320);
        default: load_view($urandom_range(0, 4194303), $urandom_range(0, 4194303),
                           rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                           $urandom_range(0, 8191));
      endcase
      fill_random(80);
      // hold the sender mid-stream until every result is back
      repeat (1500) @(posedge clk_i);
      tx_hold = 1'b1;
      do @(negedge clk_i);
      while (in_if.valid || expected_hits.size() != 0);
      tx_hold = 1'b0;
      fill_random(80);
      drain();
    end

    if (fail_count == 0) begin
      $display("[grid_raycast_dda_with_doors] OK");
    end else begin
      $display("[grid_raycast_dda_with_doors] ERROR");
    end
    $finish;
  end

endmodule
